FILE: src/plic_pkg.sv
// Shared types and constants of the platform interrupt controller.
package plic_pkg;

  localparam int SLOT_COUNT     = 32;
  localparam int ID_W           = 5;
  localparam int PRIO_W         = 3;
  localparam int PRIO_STORE_MAX = 7;
  localparam int LANES          = 8;
  localparam int LANE_W         = 3;
  localparam int ROWS           = SLOT_COUNT / LANES;
  localparam int ROW_W          = ID_W - LANE_W;
  localparam int ROW_BITS       = LANES * PRIO_W;
  localparam int CNT_W          = $clog2(ROWS + 1);

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_REQUEST = 2'd2
  } plic_cmd_e;

  typedef enum logic [1:0] {
    RGN_PRIORITY  = 2'd0,
    RGN_ENABLE    = 2'd1,
    RGN_THRESHOLD = 2'd2,
    RGN_CLAIM     = 2'd3
  } plic_region_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_SCAN,
    ST_DONE
  } plic_state_e;

  typedef struct packed {
    plic_cmd_e    command;
    plic_region_e region;
    logic [4:0]   index;
    logic [31:0]  write_data;
  } plic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic        bad_access;
  } plic_out_t;

endpackage

FILE: src/plic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module plic_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/platform_interrupt_controller.sv
// Top level of the one-target platform interrupt controller.
//
// The input channel carries register accesses and source request events;
// each accepted transfer yields exactly one result transfer on the output
// channel. A transfer is taken at a clock edge where valid is high and
// stall is low. The block works on one item at a time: in_stall_o is low
// only while it is idle, and an item can be accepted while the previous
// result still waits in the output register.
// Source priorities live in a RAM of four rows, eight sources per row.
// Finding the best source reads the four rows one after another.
// Accesses that do not change the interrupt state go straight to the
// result; a priority read first reads its row, a priority write reads its
// row, writes it back and then scans, an enable, threshold or request
// change scans once, and a claim scans once to select and once more
// to update the interrupt request. Once the previous result reaches the
// output register, the block is idle again and can take a new item. When
// the receiver stalls, the result holds and the block waits with the next
// result until the output register frees up.
// Reset clears all enables, pending and in-service bits and the threshold,
// and marks every priority row to read as zero until first written.
module platform_interrupt_controller #(
  parameter int NUM_SOURCES  = 32,
  parameter int MAX_PRIORITY = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  plic_pkg::plic_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output plic_pkg::plic_out_t out_data_o
);

  import plic_pkg::*;

  localparam int USABLE = (NUM_SOURCES < SLOT_COUNT) ? NUM_SOURCES : SLOT_COUNT;
  localparam int CAP    = (MAX_PRIORITY < PRIO_STORE_MAX) ? MAX_PRIORITY : PRIO_STORE_MAX;
  localparam logic [SLOT_COUNT-1:0] USABLE_MASK =
    ((USABLE >= SLOT_COUNT) ? {SLOT_COUNT{1'b1}}
                            : ((SLOT_COUNT'(1) << USABLE) - SLOT_COUNT'(1)))
    & ~SLOT_COUNT'(1);

  plic_state_e state_q, state_d;
  plic_in_t    req_q, req_d;
  logic [SLOT_COUNT-1:0] enable_q, enable_d;
  logic [SLOT_COUNT-1:0] pending_q, pending_d;
  logic [SLOT_COUNT-1:0] insvc_q, insvc_d;
  logic [PRIO_W-1:0]     thr_q, thr_d;
  logic                  irq_q, irq_d;
  logic [ROWS-1:0]       row_valid_q, row_valid_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  claim_pass_q, claim_pass_d;
  logic [ID_W-1:0]       best_id_q, best_id_d;
  logic [PRIO_W-1:0]     best_prio_q, best_prio_d;
  logic [31:0]           rdata_q, rdata_d;
  logic                  bad_q, bad_d;
  logic                  out_valid_q, out_valid_d;
  plic_out_t             out_data_q, out_data_d;
  logic [ROW_W-1:0]      rd_row_q;

  logic                  ram_we;
  logic [ROW_W-1:0]      ram_raddr;
  logic [ROW_BITS-1:0]   ram_wdata;
  logic [ROW_BITS-1:0]   ram_rdata;
  logic [ROW_BITS-1:0]   row_data;
  logic [ID_W-1:0]       scan_id;
  logic [PRIO_W-1:0]     scan_prio;
  logic [SLOT_COUNT-1:0] cand;

  plic_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROWS)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(req_q.index[ID_W-1 -: ROW_W]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [31:0] v);
    if (v > 32'(CAP)) begin
      return PRIO_W'(CAP);
    end
    return v[PRIO_W-1:0];
  endfunction

  function automatic logic id_ok(input logic [31:0] id);
    return (id != 32'd0) && (id < 32'(USABLE));
  endfunction

  assign row_data = row_valid_q[rd_row_q] ? ram_rdata : '0;
  assign cand     = enable_q & pending_q & USABLE_MASK;

  always_comb begin
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] p;
    scan_id   = best_id_q;
    scan_prio = best_prio_q;
    for (int j = 0; j < LANES; j++) begin
      id = {rd_row_q, LANE_W'(j)};
      p  = row_data[j*PRIO_W +: PRIO_W];
      if (cand[id] && (p > scan_prio)) begin
        scan_id   = id;
        scan_prio = p;
      end
    end
  end

  assign ram_raddr = (state_q == ST_IDLE) ? in_data_i.index[ID_W-1 -: ROW_W]
                                          : cnt_q[ROW_W-1:0];

  always_comb begin
    logic [ROW_BITS-1:0] row_new;
    logic [LANE_W-1:0]   lane;
    row_new      = row_data;
    lane         = req_q.index[LANE_W-1:0];
    state_d      = state_q;
    req_d        = req_q;
    enable_d     = enable_q;
    pending_d    = pending_q;
    insvc_d      = insvc_q;
    thr_d        = thr_q;
    irq_d        = irq_q;
    row_valid_d  = row_valid_q;
    cnt_d        = cnt_q;
    claim_pass_d = claim_pass_q;
    best_id_d    = best_id_q;
    best_prio_d  = best_prio_q;
    rdata_d      = rdata_q;
    bad_d        = bad_q;
    ram_we       = 1'b0;
    row_new[lane*PRIO_W +: PRIO_W] = clamp_prio(req_q.write_data);
    ram_wdata    = row_new;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_data_i;
          rdata_d      = '0;
          bad_d        = 1'b0;
          cnt_d        = '0;
          claim_pass_d = 1'b0;
          state_d      = ST_DONE;
          case (in_data_i.command)
            CMD_READ: begin
              unique case (in_data_i.region)
                RGN_PRIORITY: begin
                  if (id_ok(32'(in_data_i.index))) begin
                    state_d = ST_ROW;
                  end else begin
                    bad_d = 1'b1;
                  end
                end
                RGN_ENABLE:    rdata_d = enable_q & USABLE_MASK;
                RGN_THRESHOLD: rdata_d = 32'(thr_q);
                RGN_CLAIM: begin
                  claim_pass_d = 1'b1;
                  state_d      = ST_SCAN;
                end
                default: ;
              endcase
            end
            CMD_WRITE: begin
              unique case (in_data_i.region)
                RGN_PRIORITY: begin
                  if (id_ok(32'(in_data_i.index))) begin
                    state_d = ST_ROW;
                  end else begin
                    bad_d = 1'b1;
                  end
                end
                RGN_ENABLE: begin
                  enable_d = in_data_i.write_data & USABLE_MASK;
                  state_d  = ST_SCAN;
                end
                RGN_THRESHOLD: begin
                  thr_d   = clamp_prio(in_data_i.write_data);
                  state_d = ST_SCAN;
                end
                RGN_CLAIM: begin
                  if (id_ok(in_data_i.write_data)) begin
                    insvc_d[in_data_i.write_data[ID_W-1:0]] = 1'b0;
                  end else begin
                    bad_d = 1'b1;
                  end
                end
                default: ;
              endcase
            end
            CMD_REQUEST: begin
              if (id_ok(32'(in_data_i.index))) begin
                if (!pending_q[in_data_i.index] && !insvc_q[in_data_i.index]) begin
                  pending_d[in_data_i.index] = 1'b1;
                end
                state_d = ST_SCAN;
              end else begin
                bad_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROW: begin
        if (req_q.command == CMD_READ) begin
          rdata_d = 32'(row_data[lane*PRIO_W +: PRIO_W]);
          state_d = ST_DONE;
        end else begin
          ram_we                                   = 1'b1;
          row_valid_d[req_q.index[ID_W-1 -: ROW_W]] = 1'b1;
          state_d                                  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == '0) begin
          best_id_d   = '0;
          best_prio_d = thr_q;
        end else begin
          best_id_d   = scan_id;
          best_prio_d = scan_prio;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROWS)) begin
          cnt_d = '0;
          if (claim_pass_q) begin
            rdata_d      = 32'(scan_id);
            claim_pass_d = 1'b0;
            if (scan_id != '0) begin
              pending_d[scan_id] = 1'b0;
              insvc_d[scan_id]   = 1'b1;
            end
          end else begin
            irq_d   = (scan_id != '0);
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.read_data   = rdata_q;
          out_data_d.irq_request = irq_q;
          out_data_d.bad_access  = bad_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enable_q     <= '0;
      pending_q    <= '0;
      insvc_q      <= '0;
      thr_q        <= '0;
      irq_q        <= 1'b0;
      row_valid_q  <= '0;
      cnt_q        <= '0;
      claim_pass_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      enable_q     <= enable_d;
      pending_q    <= pending_d;
      insvc_q      <= insvc_d;
      thr_q        <= thr_d;
      irq_q        <= irq_d;
      row_valid_q  <= row_valid_d;
      cnt_q        <= cnt_d;
      claim_pass_q <= claim_pass_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    best_id_q   <= best_id_d;
    best_prio_q <= best_prio_d;
    rdata_q     <= rdata_d;
    bad_q       <= bad_d;
    out_data_q  <= out_data_d;
    rd_row_q    <= ram_raddr;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/plic_checker.sv
// Port-level checks of the platform interrupt controller and their binding.
module plic_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input plic_pkg::plic_in_t  in_data_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input plic_pkg::plic_out_t out_data_i
);

  import plic_pkg::*;

  a_bad_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.bad_access |-> out_data_i.read_data == 32'd0)
    else $error("Rejected access returned nonzero data.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("Second transfer accepted while an item is in work.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("Stalled result changed or was dropped.");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_i |=> in_valid_i && $stable(in_data_i))
    else $error("Stalled input transfer changed or was withdrawn.");

endmodule

bind platform_interrupt_controller plic_checker u_plic_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

FILE: tb/platform_interrupt_controller_tb.sv
// Self-checking testbench for the platform interrupt controller with directed and random accesses.
module platform_interrupt_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plic_pkg::*;

  localparam int NUM_SRC      = 32;
  localparam int MAX_PRIO     = 7;
  localparam int RAND_ITEMS   = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam plic_cmd_e CMD_UNUSED = plic_cmd_e'(2'd3);

  localparam logic [31:0] USABLE =
    (NUM_SRC >= SLOT_COUNT) ? 32'hFFFF_FFFE : (((32'd1 << NUM_SRC) - 32'd1) & ~32'd1);
  localparam logic [2:0] PRIO_CAP =
    (MAX_PRIO < PRIO_STORE_MAX) ? 3'(MAX_PRIO) : 3'(PRIO_STORE_MAX);

  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  typedef struct packed {
    plic_in_t  acc;
    logic      fixed;
    plic_out_t reply;
  } dir_row_t;

  localparam int DIR_ROWS = 27;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  plic_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  plic_out_t out_data_o;

  logic [2:0]  prio_tbl [SLOT_COUNT];
  logic [31:0] en_bits;
  logic [31:0] pend_bits;
  logic [31:0] insvc_bits;
  logic [2:0]  thresh;

  plic_out_t bus_replies [$];
  int        fault_count = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;
  dir_row_t  dir_rows [DIR_ROWS];

  platform_interrupt_controller #(
    .NUM_SOURCES (NUM_SRC),
    .MAX_PRIORITY(MAX_PRIO)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic src_ok(logic [31:0] id);
    return id != 32'd0 && id < NUM_SRC && id < SLOT_COUNT;
  endfunction

  function automatic logic [2:0] clamp_prio(logic [31:0] v);
    return (v > 32'(PRIO_CAP)) ? PRIO_CAP : v[2:0];
  endfunction

  function automatic logic [4:0] best_source();
    logic [31:0] cand;
    logic [4:0]  best;
    logic [2:0]  best_prio;
    cand      = en_bits & pend_bits & USABLE;
    best      = '0;
    best_prio = thresh;
    for (int i = 1; i < SLOT_COUNT; i++) begin
      if (cand[i] && prio_tbl[i] > best_prio) begin
        best      = 5'(i);
        best_prio = prio_tbl[i];
      end
    end
    return best;
  endfunction

  function automatic plic_out_t plic_apply(plic_in_t a);
    plic_out_t  r;
    logic [4:0] pick;
    r = '0;
    case (a.command)
      CMD_READ: begin
        case (a.region)
          RGN_PRIORITY: begin
            if (src_ok(32'(a.index))) r.read_data = 32'(prio_tbl[a.index]);
            else r.bad_access = 1'b1;
          end
          RGN_ENABLE:    r.read_data = en_bits & USABLE;
          RGN_THRESHOLD: r.read_data = 32'(thresh);
          RGN_CLAIM: begin
            pick = best_source();
            if (pick != '0) begin
              pend_bits[pick]  = 1'b0;
              insvc_bits[pick] = 1'b1;
            end
            r.read_data = 32'(pick);
          end
        endcase
      end
      CMD_WRITE: begin
        case (a.region)
          RGN_PRIORITY: begin
            if (src_ok(32'(a.index))) prio_tbl[a.index] = clamp_prio(a.write_data);
            else r.bad_access = 1'b1;
          end
          RGN_ENABLE:    en_bits = a.write_data & USABLE;
          RGN_THRESHOLD: thresh = clamp_prio(a.write_data);
          RGN_CLAIM: begin
            if (src_ok(a.write_data)) insvc_bits[a.write_data[4:0]] = 1'b0;
            else r.bad_access = 1'b1;
          end
        endcase
      end
      CMD_REQUEST: begin
        if (src_ok(32'(a.index))) begin
          if (!pend_bits[a.index] && !insvc_bits[a.index]) pend_bits[a.index] = 1'b1;
        end else begin
          r.bad_access = 1'b1;
        end
      end
      default: ;
    endcase
    r.irq_request = (best_source() != '0);
    return r;
  endfunction

  function automatic dir_row_t row(plic_cmd_e cmd, plic_region_e rgn, logic [4:0] idx,
                                   logic [31:0] wd, logic fixed, logic [31:0] rd,
                                   logic irq, logic bad);
    dir_row_t d;
    d.acc.command     = cmd;
    d.acc.region      = rgn;
    d.acc.index       = idx;
    d.acc.write_data  = wd;
    d.fixed           = fixed;
    d.reply.read_data   = rd;
    d.reply.irq_request = irq;
    d.reply.bad_access  = bad;
    return d;
  endfunction

  function automatic plic_in_t next_access();
    plic_in_t    a;
    int unsigned roll;
    int unsigned start;
    int unsigned id;
    a.command    = CMD_READ;
    a.region     = plic_region_e'(2'($urandom_range(0, 3)));
    a.index      = 5'($urandom);
    a.write_data = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      a.command = CMD_REQUEST;
      a.index   = ($urandom_range(0, 29) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    end else if (roll < 40) begin
      a.region = RGN_CLAIM;
    end else if (roll < 52) begin
      a.command = CMD_WRITE;
      a.region  = RGN_CLAIM;
      if ($urandom_range(0, 4) != 0) begin
        start        = $urandom_range(1, 31);
        a.write_data = start;
        for (int k = 0; k < 31; k++) begin
          id = 1 + (start - 1 + k) % 31;
          if (insvc_bits[id]) begin
            a.write_data = id;
            break;
          end
        end
      end
    end else if (roll < 64) begin
      a.command = CMD_WRITE;
      a.region  = RGN_PRIORITY;
      if ($urandom_range(0, 4) != 0) a.write_data = $urandom_range(0, 7);
    end else if (roll < 72) begin
      a.region = RGN_PRIORITY;
    end else if (roll < 78) begin
      a.command = CMD_WRITE;
      a.region  = RGN_ENABLE;
      if ($urandom_range(0, 3) != 0) a.write_data = $urandom | $urandom;
    end else if (roll < 84) begin
      a.command = CMD_WRITE;
      a.region  = RGN_THRESHOLD;
      if ($urandom_range(0, 4) != 0) a.write_data = $urandom_range(0, 4);
    end else if (roll < 90) begin
      a.region = ($urandom_range(0, 1) != 0) ? RGN_ENABLE : RGN_THRESHOLD;
    end else if (roll < 95) begin
      a.command = CMD_UNUSED;
    end else begin
      a.command = plic_cmd_e'(2'($urandom_range(0, 3)));
    end
    return a;
  endfunction

  task automatic push_access(input plic_in_t a, input logic fixed, input plic_out_t fixed_reply);
    plic_out_t r;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = a;
    do @(posedge clk_i); while (in_stall_o);
    r = plic_apply(a);
    if (fixed) r = fixed_reply;
    bus_replies.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    plic_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("Unexpected transfer: read_data=%h irq_request=%b bad_access=%b",
                   out_data_o.read_data, out_data_o.irq_request, out_data_o.bad_access);
      end else begin
        want = bus_replies.pop_front();
        if (out_data_o.read_data !== want.read_data ||
            out_data_o.irq_request !== want.irq_request ||
            out_data_o.bad_access !== want.bad_access) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("Mismatch: expected read_data=%h irq_request=%b bad_access=%b, got %h %b %b",
                     want.read_data, want.irq_request, want.bad_access,
                     out_data_o.read_data, out_data_o.irq_request, out_data_o.bad_access);
        end
      end
    end
  end

  initial begin
    int mode;
    int len;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i = 1'b0;
          STALL_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
          default:     out_stall_i = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) prio_tbl[i] = '0;
    en_bits    = '0;
    pend_bits  = '0;
    insvc_bits = '0;
    thresh     = '0;

    dir_rows = '{
      row(CMD_READ,    RGN_PRIORITY,  5'd5,  32'd0,          1'b1, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_PRIORITY,  5'd0,  32'd0,          1'b1, 32'd0,          1'b0, 1'b1),
      row(CMD_WRITE,   RGN_PRIORITY,  5'd0,  32'd5,          1'b1, 32'd0,          1'b0, 1'b1),
      row(CMD_READ,    RGN_ENABLE,    5'd0,  32'd0,          1'b1, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_CLAIM,     5'd0,  32'd0,          1'b1, 32'd0,          1'b0, 1'b0),
      row(CMD_REQUEST, RGN_PRIORITY,  5'd0,  32'd0,          1'b1, 32'd0,          1'b0, 1'b1),
      row(CMD_WRITE,   RGN_CLAIM,     5'd0,  32'd0,          1'b1, 32'd0,          1'b0, 1'b1),
      row(CMD_WRITE,   RGN_CLAIM,     5'd0,  32'd32,         1'b1, 32'd0,          1'b0, 1'b1),
      row(CMD_WRITE,   RGN_CLAIM,     5'd0,  32'hFFFF_FFFF,  1'b1, 32'd0,          1'b0, 1'b1),
      row(CMD_WRITE,   RGN_PRIORITY,  5'd31, 32'hFFFF_FFFF,  1'b1, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_PRIORITY,  5'd31, 32'd0,          1'b1, 32'd7,          1'b0, 1'b0),
      row(CMD_WRITE,   RGN_PRIORITY,  5'd1,  32'd3,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_WRITE,   RGN_PRIORITY,  5'd2,  32'd3,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_WRITE,   RGN_ENABLE,    5'd0,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_ENABLE,    5'd0,  32'd0,          1'b1, 32'hFFFF_FFFE,  1'b0, 1'b0),
      row(CMD_REQUEST, RGN_PRIORITY,  5'd2,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_REQUEST, RGN_ENABLE,    5'd1,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_REQUEST, RGN_CLAIM,     5'd31, 32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_CLAIM,     5'd0,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_CLAIM,     5'd0,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_REQUEST, RGN_PRIORITY,  5'd1,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_WRITE,   RGN_THRESHOLD, 5'd0,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_THRESHOLD, 5'd0,  32'd0,          1'b1, 32'd7,          1'b0, 1'b0),
      row(CMD_WRITE,   RGN_THRESHOLD, 5'd0,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_WRITE,   RGN_PRIORITY,  5'd2,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_READ,    RGN_CLAIM,     5'd0,  32'd0,          1'b0, 32'd0,          1'b0, 1'b0),
      row(CMD_UNUSED,  RGN_CLAIM,     5'd31, 32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0, 1'b0)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      push_access(dir_rows[i].acc, dir_rows[i].fixed, dir_rows[i].reply);
    for (int i = 0; i < RAND_ITEMS; i++)
      push_access(next_access(), 1'b0, '0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (bus_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
